### hdl/ascii_decimal_int16_parser_defines.svh
// Assertion macros for the ascii_decimal_int16_parser RTL, used in adip_parse_core.
// ADIP_ASSERT is sampled on the clock and disabled in reset.
// ADIP_ASSERT_ANY is sampled on the clock in every cycle, including reset.
`ifndef ASCII_DECIMAL_INT16_PARSER_DEFINES_SVH
`define ASCII_DECIMAL_INT16_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ADIP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ADIP_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ADIP_ASSERT(lbl, clk, rst_n, prop, msg)
`define ADIP_ASSERT_ANY(lbl, clk, prop, msg)
`endif

`endif

### hdl/adip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adip_pkg: types and constants of the ASCII decimal parser
// Word structs for both channels, the stage handoff struct, the phase enum
// and the character codes the parser tests against.
// ----------------------------------------------------------------------------
package adip_pkg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] parsed_value;
        logic               parse_ok;
    } t_out_word;

    // Handoff from the input register to the parse core.
    typedef struct packed {
        logic     adv;
        t_in_word word;
    } t_step;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_SIGN   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_TRAIL  = 3'd3,
        PH_FAIL   = 3'd4
    } t_phase;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Running magnitude times ten plus a digit fits in 19 bits.
    localparam int unsigned       ACC_W     = 19;
    localparam logic [ACC_W-1:0]  LIMIT_POS = 19'd32767;
    localparam logic [ACC_W-1:0]  LIMIT_NEG = 19'd32768;

endpackage

### hdl/ascii_decimal_int16_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_decimal_int16_parser: ASCII decimal token to signed 16-bit value
// Takes one byte per word with a last-byte flag and gives one result word per
// token: ok and the value, or not ok with value zero.
//
//   channel | direction | handshake                  | word
//   in      | input     | i_in_valid / o_in_stall    | i_in_word  (char, last)
//   out     | output    | o_out_valid / i_out_stall  | o_out_word (value, ok)
//
// One byte a cycle unless a last byte waits on a stalled output; the last
// byte of a token sits in the input register until the result register has
// room, then the result register loads and the result word becomes valid.
// The sign/magnitude update is a single shift-add and compare per byte.
// Synchronous active-low reset clears the token state and both valids.
// Only a last byte waits on a stalled output; other bytes keep flowing.
// ----------------------------------------------------------------------------
module ascii_decimal_int16_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  adip_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output adip_pkg::t_out_word o_out_word
);
    import adip_pkg::*;

    t_step step;
    logic  slot_free;

    adip_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_slot_free (slot_free),
        .o_step      (step)
    );

    adip_parse_core u_parse_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .o_slot_free (slot_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

### hdl/adip_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adip_in_stage: input register of the parser
// Holds one incoming word and releases it to the parse core. A word that is
// not the last of its token always moves on; a last word waits for room in
// the result register.
// ----------------------------------------------------------------------------
module adip_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  adip_pkg::t_in_word i_in_word,
    input  logic              i_slot_free,
    output adip_pkg::t_step   o_step
);
    import adip_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_word r_word;
    logic     adv;
    logic     load;

    assign adv        = r_valid && (!r_word.last_byte || i_slot_free);
    assign o_in_stall = r_valid && !adv;
    assign load       = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= i_in_word;
        end
    end

    assign o_step.adv  = adv;
    assign o_step.word = r_word;

endmodule

### hdl/adip_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adip_parse_core: token state machine and result register
// Updates phase, sign and magnitude for each released byte and loads the
// result register on the last byte of a token.
// ----------------------------------------------------------------------------
`include "ascii_decimal_int16_parser_defines.svh"

module adip_parse_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  adip_pkg::t_step    i_step,
    output logic               o_slot_free,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output adip_pkg::t_out_word o_out_word
);
    import adip_pkg::*;

    t_phase           r_phase;
    t_phase           n_phase;
    logic             r_neg;
    logic             n_neg;
    logic [15:0]      r_mag;
    logic [15:0]      n_mag;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_word        r_out;
    t_out_word        n_out;

    t_phase           ph_after;
    logic             neg_after;
    logic [15:0]      mag_after;
    logic [7:0]       c;
    logic             is_blank;
    logic             is_digit;
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] lim;
    logic             done;

    assign c        = i_step.word.char_byte;
    assign is_blank = c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_FF, CH_VT};
    assign is_digit = c inside {[CH_ZERO:CH_NINE]};
    // mag * 10 + digit, as (mag << 3) + (mag << 1) + digit
    assign acc = {r_mag, 3'b000} + {2'b00, r_mag, 1'b0} + {15'd0, c[3:0]};
    assign lim = (r_phase == PH_LEAD) ? LIMIT_POS : (r_neg ? LIMIT_NEG : LIMIT_POS);
    assign done = i_step.adv && i_step.word.last_byte;

    // Phase, sign and magnitude after this byte.
    always_comb begin
        ph_after  = r_phase;
        neg_after = r_neg;
        mag_after = r_mag;
        case (r_phase)
            PH_LEAD: begin
                if (is_blank) begin
                    ph_after = PH_LEAD;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    neg_after = (c == CH_MINUS);
                    ph_after  = PH_SIGN;
                end else if (is_digit) begin
                    if (acc > lim) begin
                        ph_after = PH_FAIL;
                    end else begin
                        mag_after = acc[15:0];
                        ph_after  = PH_DIGITS;
                    end
                end else begin
                    ph_after = PH_FAIL;
                end
            end
            PH_SIGN, PH_DIGITS: begin
                if (is_digit) begin
                    if (acc > lim) begin
                        ph_after = PH_FAIL;
                    end else begin
                        mag_after = acc[15:0];
                        ph_after  = PH_DIGITS;
                    end
                end else if (r_phase == PH_DIGITS && (is_blank || c == CH_NUL)) begin
                    ph_after = PH_TRAIL;
                end else begin
                    ph_after = PH_FAIL;
                end
            end
            PH_TRAIL: begin
                if (!(is_blank || c == CH_NUL)) begin
                    ph_after = PH_FAIL;
                end
            end
            default: begin
                ph_after = PH_FAIL;
            end
        endcase
    end

    // Next state: hold when idle, restart after the last byte.
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_mag   = r_mag;
        if (i_step.adv) begin
            if (i_step.word.last_byte) begin
                n_phase = PH_LEAD;
                n_neg   = 1'b0;
                n_mag   = 16'd0;
            end else begin
                n_phase = ph_after;
                n_neg   = neg_after;
                n_mag   = mag_after;
            end
        end
    end

    // Result word and result register control.
    always_comb begin
        n_out.parse_ok     = (ph_after == PH_DIGITS) || (ph_after == PH_TRAIL);
        n_out.parsed_value = '0;
        if (n_out.parse_ok) begin
            n_out.parsed_value = neg_after ? 16'(16'd0 - mag_after) : mag_after;
        end
        o_slot_free = !r_out_valid || !i_out_stall;
        n_out_valid = r_out_valid && i_out_stall;
        if (done) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_neg       <= 1'b0;
            r_mag       <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_mag       <= n_mag;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `ADIP_ASSERT(a_fail_zero, i_clk, i_rst_n, r_out_valid && !r_out.parse_ok |-> r_out.parsed_value == 16'sd0, "failed result carries a nonzero value")
    `ADIP_ASSERT(a_restart, i_clk, i_rst_n, done |=> (r_phase == PH_LEAD && r_mag == 16'd0 && !r_neg), "state not cleared after last byte")
    `ADIP_ASSERT(a_mag_bound, i_clk, i_rst_n, r_mag <= 16'd32768, "magnitude above negative limit")
    `ADIP_ASSERT(a_no_overwrite, i_clk, i_rst_n, r_out_valid && i_out_stall |-> !done, "result overwritten while stalled")
    `ADIP_ASSERT_ANY(a_reset_idle, i_clk, !i_rst_n |=> !r_out_valid, "result valid right after reset")

endmodule

### dv/ascii_decimal_int16_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_decimal_int16_parser_test: self-checking bench for the decimal parser
// Feeds text tokens byte by byte and predicts the ok flag and 16-bit value of
// every token. Each result word is checked against the oldest prediction.
// A directed set of edge tokens is followed by random tokens under several
// idle and stall mixes, with one long output hold-off.
// ----------------------------------------------------------------------------
module ascii_decimal_int16_parser_test;
    import adip_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_BYTES = 360;

    // Token prediction and result checking.
    class parse_scoreboard;
        t_phase      phase;
        bit          negative;
        logic [15:0] magnitude;
        t_out_word   expected_q[$];
        int unsigned errors;

        function new();
            errors = 0;
            clear_token();
        endfunction

        function void clear_token();
            phase     = PH_LEAD;
            negative  = 1'b0;
            magnitude = 16'd0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_FF, CH_VT};
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function void add_digit(logic [7:0] c);
            int unsigned sum;
            int unsigned bound;
            bound = 32'(negative ? LIMIT_NEG : LIMIT_POS);
            sum   = 32'(magnitude) * 32'd10 + (32'(c) - 32'(CH_ZERO));
            if (sum > bound) begin
                phase = PH_FAIL;
            end else begin
                magnitude = sum[15:0];
                phase     = PH_DIGITS;
            end
        endfunction

        function void note_input(t_in_word w);
            logic [7:0] c;
            t_out_word  res;
            c = w.char_byte;
            case (phase)
                PH_LEAD: begin
                    if (is_blank(c)) begin
                        phase = PH_LEAD;
                    end else if (c == CH_PLUS || c == CH_MINUS) begin
                        negative = (c == CH_MINUS);
                        phase    = PH_SIGN;
                    end else if (is_digit(c)) begin
                        add_digit(c);
                    end else begin
                        phase = PH_FAIL;
                    end
                end
                PH_SIGN: begin
                    if (is_digit(c)) add_digit(c);
                    else phase = PH_FAIL;
                end
                PH_DIGITS: begin
                    if (is_digit(c)) add_digit(c);
                    else if (is_blank(c) || c == CH_NUL) phase = PH_TRAIL;
                    else phase = PH_FAIL;
                end
                PH_TRAIL: begin
                    if (!(is_blank(c) || c == CH_NUL)) phase = PH_FAIL;
                end
                default: phase = PH_FAIL;
            endcase
            if (w.last_byte) begin
                if (phase == PH_DIGITS || phase == PH_TRAIL) begin
                    res.parsed_value = negative ? 16'd0 - magnitude : magnitude;
                    res.parse_ok     = 1'b1;
                end else begin
                    res.parsed_value = 16'sd0;
                    res.parse_ok     = 1'b0;
                end
                expected_q.push_back(res);
                clear_token();
            end
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result word: value %0d ok %0b",
                             $time, got.parsed_value, got.parse_ok);
                return;
            end
            want = expected_q.pop_front();
            if (got.parsed_value !== want.parsed_value || got.parse_ok !== want.parse_ok) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch: expected value %0d ok %0b, got value %0d ok %0b",
                             $time, want.parsed_value, want.parse_ok,
                             got.parsed_value, got.parse_ok);
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    parse_scoreboard sb = new();

    logic [7:0]  token_bytes[$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_left      = 0;
    int unsigned bytes_sent     = 0;
    int unsigned cycle_count    = 0;

    ascii_decimal_int16_parser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL ascii_decimal_int16_parser");
        $finish;
    end

    // Output side: check accepted words, then pick the stall for the next cycle.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_word);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    task automatic send_word(input t_in_word w);
        int unsigned gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(w);
        bytes_sent++;
    endtask

    task automatic send_token();
        t_in_word w;
        for (int i = 0; i < token_bytes.size(); i++) begin
            w.char_byte = token_bytes[i];
            w.last_byte = (i == token_bytes.size() - 1);
            send_word(w);
        end
        token_bytes.delete();
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) token_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_CR;
            4: return CH_FF;
            default: return CH_VT;
        endcase
    endfunction

    function automatic void add_wellformed();
        int unsigned mag;
        repeat ($urandom_range(0, 2)) token_bytes.push_back(pick_blank());
        case ($urandom_range(0, 2))
            1: token_bytes.push_back(CH_PLUS);
            2: token_bytes.push_back(CH_MINUS);
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0: mag = $urandom_range(0, 99);
            1: mag = $urandom_range(0, 32768);
            2: mag = 32760 + $urandom_range(0, 15);
            default: mag = $urandom_range(0, 99999);
        endcase
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) token_bytes.push_back(CH_ZERO);
        add_text($sformatf("%0d", mag));
        repeat ($urandom_range(0, 2))
            token_bytes.push_back($urandom_range(0, 1) ? CH_NUL : pick_blank());
    endfunction

    task automatic send_random_token();
        int unsigned roll;
        int unsigned idx;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            add_wellformed();
        end else if (roll < 85) begin
            repeat ($urandom_range(1, 5)) token_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            // corrupt one byte of an otherwise good token
            add_wellformed();
            idx = $urandom_range(0, token_bytes.size() - 1);
            case ($urandom_range(0, 3))
                0: token_bytes[idx] = CH_PLUS;
                1: token_bytes[idx] = CH_MINUS;
                2: token_bytes[idx] = CH_NUL;
                default: token_bytes[idx] = 8'($urandom_range(0, 255));
            endcase
        end
        send_token();
    endtask

    task automatic run_random(input int unsigned idle_pct, input int unsigned stall_pct,
                              input int unsigned count);
        int unsigned stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = bytes_sent + count;
        while (bytes_sent < stop_at) send_random_token();
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed edge tokens
        add_text("7");        send_token();
        add_text("-32768");   send_token();
        add_text("32767");    send_token();
        add_text("32768");    send_token();
        add_text("-32769");   send_token();
        add_text("+0");       send_token();
        add_text("00032767"); send_token();
        add_text("-");        send_token();
        add_text("+-3");      send_token();
        add_text("327670");   send_token();
        add_text("12x34");    send_token();
        add_text("12 3");     send_token();
        token_bytes = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_FF, CH_VT, CH_MINUS, CH_NINE,
                        CH_NUL, CH_SPACE};
        send_token();
        token_bytes = '{CH_NUL, CH_ZERO};
        send_token();
        token_bytes = '{8'hFF};
        send_token();
        wait_drained();

        run_random(0, 0, RANDOM_BYTES / 4);
        run_random(67, 0, RANDOM_BYTES / 4);

        // hold the output long enough that the block backs up into its input
        hold_req = 400;
        recv_stall_pct = 67;
        repeat (12) begin
            add_wellformed();
            send_token();
        end
        wait_drained();

        run_random(0, 67, RANDOM_BYTES / 4);
        run_random(32, 32, RANDOM_BYTES / 4);

        recv_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS ascii_decimal_int16_parser");
        end else begin
            $display("FAIL ascii_decimal_int16_parser");
        end
        $finish;
    end

endmodule
